### design/eet_pkg.sv
package eet_pkg;

    localparam int OPERAND_WIDTH = 31;
    localparam int ROW_W         = 6;
    localparam int MAX_ROWS      = 48;
    localparam int DIV_CNT_W     = $clog2(OPERAND_WIDTH + 1);

    typedef struct packed {
        logic [OPERAND_WIDTH-1:0] value_a;
        logic [OPERAND_WIDTH-1:0] value_b;
    } operands_t;

    typedef struct packed {
        logic [OPERAND_WIDTH-1:0] remainder;
        logic [OPERAND_WIDTH-1:0] coeff_a;
        logic [OPERAND_WIDTH-1:0] coeff_b;
        logic                     negated;
        logic [ROW_W-1:0]         row_index;
        logic                     last_row;
        logic                     bad_input;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_CHECK,
        ST_MUL_S,
        ST_MUL_T
    } state_t;

endpackage

### design/eet_div.sv
module eet_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic [eet_pkg::OPERAND_WIDTH-1:0] dividend,
    input  logic [eet_pkg::OPERAND_WIDTH-1:0] divisor,
    output logic [eet_pkg::OPERAND_WIDTH-1:0] quotient,
    output logic [eet_pkg::OPERAND_WIDTH-1:0] remainder,
    output logic                              done
);

    localparam int W = eet_pkg::OPERAND_WIDTH;

    logic [W-1:0]                   rem_reg, rem_next;
    logic [W-1:0]                   quo_reg, quo_next;
    logic [eet_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [W:0]                     shifted;
    logic [W:0]                     diff;

    // one restoring step per cycle, quotient bits shift in from the bottom
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (go)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = eet_pkg::DIV_CNT_W'(W);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == eet_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

### design/extended_euclid_table_top.sv
// Extended Euclid table: on a start beat with a and b the block emits one result beat per row of
// the remainder sequence (a, b, ..., gcd), up to MAX_ROWS rows, with cofactor magnitudes and sign;
// the gcd row carries last_row, and b of zero gives a single bad_input row. Beats come on
// result_valid for one cycle each and must be taken; busy drops in the cycle that the final row is
// on the result ports. Row 0 is registered and leaves in the cycle after start; every later row
// costs one pass of the shared restoring divider, one quotient bit per cycle, plus the DIV_GO,
// CHECK, MUL_S and MUL_T states of sequencing and cofactor multiply-add.
module extended_euclid_table_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  eet_pkg::operands_t  operands,
    output logic                busy,
    output logic                result_valid,
    output eet_pkg::result_t    result
);

    localparam int W = eet_pkg::OPERAND_WIDTH;

    eet_pkg::state_t state_reg, state_next;

    logic [W-1:0] prev_rem_reg, cur_rem_reg;
    logic [W-1:0] prev_s_reg, cur_s_reg;
    logic [W-1:0] prev_t_reg, cur_t_reg;
    logic [W-1:0] s_new_reg;
    logic [eet_pkg::ROW_W-1:0] n_reg;
    logic [eet_pkg::ROW_W-1:0] cur_idx;

    logic           accept;
    logic           div_go;
    logic           div_done;
    logic [W-1:0]   div_q, div_r;
    logic [W-1:0]   mul_x, mul_add;
    logic [2*W-1:0] prod_full;
    logic [W-1:0]   mac;
    logic           rem_zero;
    logic           at_cap;

    eet_pkg::result_t res_reg, res_next;
    logic             res_valid_reg, res_valid_next;

    assign accept   = start && (state_reg == eet_pkg::ST_IDLE);
    assign rem_zero = (div_r == '0);
    assign at_cap   = (n_reg >= eet_pkg::ROW_W'(eet_pkg::MAX_ROWS));
    assign cur_idx  = n_reg - 1'b1;

    eet_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (prev_rem_reg),
        .divisor   (cur_rem_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // shared multiply-add, cofactor a then cofactor b; product kept modulo the operand width
    assign mul_x     = (state_reg == eet_pkg::ST_MUL_S) ? cur_s_reg  : cur_t_reg;
    assign mul_add   = (state_reg == eet_pkg::ST_MUL_S) ? prev_s_reg : prev_t_reg;
    assign prod_full = {{W{1'b0}}, div_q} * {{W{1'b0}}, mul_x};
    assign mac       = prod_full[W-1:0] + mul_add;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eet_pkg::ST_IDLE:
            begin
                if (start && (operands.value_b != '0))
                begin
                    state_next = eet_pkg::ST_DIV_GO;
                end
            end
            eet_pkg::ST_DIV_GO:   state_next = eet_pkg::ST_DIV_WAIT;
            eet_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = eet_pkg::ST_CHECK;
                end
            end
            eet_pkg::ST_CHECK:
            begin
                if (rem_zero || at_cap)
                begin
                    state_next = eet_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = eet_pkg::ST_MUL_S;
                end
            end
            eet_pkg::ST_MUL_S:    state_next = eet_pkg::ST_MUL_T;
            eet_pkg::ST_MUL_T:    state_next = eet_pkg::ST_DIV_GO;
            default:              state_next = eet_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = 1'b0;
        div_go         = 1'b0;
        unique case (state_reg)
            eet_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    if (operands.value_b == '0)
                    begin
                        res_next.bad_input = 1'b1;
                    end
                    else
                    begin
                        res_next.remainder = operands.value_a;
                        res_next.coeff_a   = W'(1);
                    end
                end
            end
            eet_pkg::ST_DIV_GO:
            begin
                div_go = 1'b1;
            end
            eet_pkg::ST_CHECK:
            begin
                // the pending row goes out once we know whether it divides the one before
                res_valid_next     = 1'b1;
                res_next.remainder = cur_rem_reg;
                res_next.coeff_a   = cur_s_reg;
                res_next.coeff_b   = cur_t_reg;
                res_next.negated   = cur_idx[0];
                res_next.row_index = cur_idx;
                res_next.last_row  = rem_zero;
                res_next.bad_input = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eet_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            prev_rem_reg <= operands.value_a;
            cur_rem_reg  <= operands.value_b;
            prev_s_reg   <= W'(1);
            cur_s_reg    <= '0;
            prev_t_reg   <= '0;
            cur_t_reg    <= W'(1);
            n_reg        <= eet_pkg::ROW_W'(2);
        end
        else if (state_reg == eet_pkg::ST_MUL_S)
        begin
            s_new_reg <= mac;
        end
        else if (state_reg == eet_pkg::ST_MUL_T)
        begin
            prev_rem_reg <= cur_rem_reg;
            cur_rem_reg  <= div_r;
            prev_s_reg   <= cur_s_reg;
            cur_s_reg    <= s_new_reg;
            prev_t_reg   <= cur_t_reg;
            cur_t_reg    <= mac;
            n_reg        <= n_reg + 1'b1;
        end
    end

    assign busy         = (state_reg != eet_pkg::ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operands.value_b == '0) |=> result_valid && result.bad_input && !busy)
        else $error("zero divisor must give one error beat and stay idle");

    a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operands.value_b != '0) |=> result_valid && busy
            && (result.row_index == '0) && !result.last_row)
        else $error("row 0 must leave one cycle after start and keep the block busy");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_row |-> !busy)
        else $error("last row seen while the sequencer is still running");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == eet_pkg::ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

endmodule

### dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W              = eet_pkg::OPERAND_WIDTH;
    localparam int RW             = eet_pkg::ROW_W;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef logic [W-1:0] operand_t;

    localparam operand_t OP_MAX = {W{1'b1}};

    logic               clk;
    logic               rst_n;
    logic               start;
    eet_pkg::operands_t operands;
    logic               busy;
    logic               result_valid;
    eet_pkg::result_t   result;

    eet_pkg::result_t   pending_rows[$];
    int        error_count;
    int        pairs_sent;
    int        rows_seen;
    int        bad_pairs;
    int        idle_cycles;
    int        burst_left;

    extended_euclid_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .operands     (operands),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // builds the full remainder table for one pair
    task automatic predict_euclid_rows(input operand_t a,
                                       input operand_t b);
        logic [63:0]      r0, r1, s0, s1, t0, t1, q, rn, sn, tn;
        int               n;
        eet_pkg::result_t row;
        row = '0;
        if (b == '0)
        begin
            row.bad_input = 1'b1;
            pending_rows.push_back(row);
            bad_pairs++;
            return;
        end
        r0 = 64'(a);  r1 = 64'(b);  s0 = 64'd1;  s1 = 64'd0;  t0 = 64'd0;  t1 = 64'd1;
        row.remainder = a;  row.coeff_a = operand_t'(1);
        pending_rows.push_back(row);
        row = '0;
        row.remainder = b;  row.coeff_b = operand_t'(1);  row.row_index = RW'(1);
        row.negated = 1'b1;
        pending_rows.push_back(row);
        n = 2;
        forever
        begin
            if (r0 % r1 == 64'd0)
            begin
                pending_rows[pending_rows.size()-1].last_row = 1'b1;
                break;
            end
            if (n >= eet_pkg::MAX_ROWS)
                break;
            q  = r0 / r1;
            rn = r0 % r1;
            sn = (q * s1 + s0) & 64'(OP_MAX);
            tn = (q * t1 + t0) & 64'(OP_MAX);
            r0 = r1;  r1 = rn;  s0 = s1;  s1 = sn;  t0 = t1;  t1 = tn;
            row = '0;
            row.remainder = rn[W-1:0];
            row.coeff_a   = sn[W-1:0];
            row.coeff_b   = tn[W-1:0];
            row.row_index = n[RW-1:0];
            row.negated   = n[0];
            pending_rows.push_back(row);
            n++;
        end
    endtask

    // bursty sender: gaps between bursts, a beat raised only while the block is idle
    task automatic send_pair(input operand_t a,
                             input operand_t b);
        int          gap;
        logic [63:0] noise;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 6);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        do
            @(negedge clk);
        while (busy);
        start             <= 1'b1;
        operands.value_a  <= a;
        operands.value_b  <= b;
        @(posedge clk);
        predict_euclid_rows(a, b);
        pairs_sent++;
        @(negedge clk);
        noise     = {$urandom, $urandom};
        start    <= 1'b0;
        operands <= noise[$bits(eet_pkg::operands_t)-1:0];
    endtask

    function automatic operand_t rand_operand();
        case ($urandom_range(0, 3))
            0:       return operand_t'($urandom_range(1, 300));
            1:       return operand_t'($urandom_range(1, 70000));
            2:       return OP_MAX - operand_t'($urandom_range(0, 1000));
            default: return operand_t'($urandom);
        endcase
    endfunction

    // sampled at the rising edge, so beats compare against state before this edge
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            eet_pkg::result_t want;
            rows_seen++;
            if (pending_rows.size() == 0)
            begin
                $error("unexpected result beat: remainder %0d row %0d",
                       result.remainder, result.row_index);
                error_count++;
            end
            else
            begin
                want = pending_rows.pop_front();
                if (result.remainder !== want.remainder)
                begin
                    $error("remainder: expected %0d, got %0d", want.remainder, result.remainder);
                    error_count++;
                end
                if (result.coeff_a !== want.coeff_a)
                begin
                    $error("coeff_a: expected %0d, got %0d", want.coeff_a, result.coeff_a);
                    error_count++;
                end
                if (result.coeff_b !== want.coeff_b)
                begin
                    $error("coeff_b: expected %0d, got %0d", want.coeff_b, result.coeff_b);
                    error_count++;
                end
                if (result.negated !== want.negated)
                begin
                    $error("negated: expected %0b, got %0b", want.negated, result.negated);
                    error_count++;
                end
                if (result.row_index !== want.row_index)
                begin
                    $error("row_index: expected %0d, got %0d", want.row_index, result.row_index);
                    error_count++;
                end
                if (result.last_row !== want.last_row)
                begin
                    $error("last_row: expected %0b, got %0b", want.last_row, result.last_row);
                    error_count++;
                end
                if (result.bad_input !== want.bad_input)
                begin
                    $error("bad_input: expected %0b, got %0b", want.bad_input, result.bad_input);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles with neither a start beat nor a result beat
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d rows outstanding", pending_rows.size());
            $display("** extended_euclid_table_top: FAILED **");
            $finish;
        end
    end

    task automatic test_edge_operands();
        send_pair(operand_t'(1), operand_t'(1));
        send_pair(OP_MAX, OP_MAX);
        send_pair(OP_MAX, operand_t'(1));
        send_pair(operand_t'(1), OP_MAX);
        send_pair(OP_MAX, OP_MAX - operand_t'(1));
        send_pair(31'h5555_5555, 31'h2AAA_AAAA);
        send_pair(operand_t'(240), operand_t'(46));
    endtask

    task automatic test_zero_operands();
        send_pair(OP_MAX, '0);
        send_pair('0, '0);
        send_pair('0, operand_t'(17));
        send_pair('0, OP_MAX);
        send_pair(operand_t'(12345), '0);
    endtask

    task automatic test_a_below_b();
        send_pair(operand_t'(3), operand_t'(10));
        send_pair(operand_t'(46), operand_t'(240));
        send_pair(operand_t'(1), operand_t'(2));
    endtask

    // consecutive fibonacci numbers give the longest remainder chains
    task automatic test_fibonacci_chains();
        logic [63:0] f0, f1, fn;
        f0 = 64'd1;
        f1 = 64'd1;
        while (f0 + f1 <= 64'(OP_MAX))
        begin
            fn = f0 + f1;
            f0 = f1;
            f1 = fn;
        end
        send_pair(f1[W-1:0], f0[W-1:0]);
        send_pair(f0[W-1:0], f1[W-1:0]);
        send_pair(operand_t'(1346269), operand_t'(832040));
    endtask

    task automatic test_random_pairs(input int count);
        operand_t a, b, g;
        for (int i = 0; i < count; i++)
        begin
            a = rand_operand();
            b = rand_operand();
            case ($urandom_range(0, 15))
                0:       b = '0;
                1:       a = '0;
                2:
                begin
                    // shared factor so the gcd is not one
                    g = operand_t'($urandom_range(2, 5000));
                    a = operand_t'(64'(g) * 64'($urandom_range(1, 400000)));
                    b = operand_t'(64'(g) * 64'($urandom_range(1, 400000)));
                end
                default: ;
            endcase
            send_pair(a, b);
        end
    endtask

    task automatic drain_rows();
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        error_count = 0;
        pairs_sent  = 0;
        rows_seen   = 0;
        bad_pairs   = 0;
        idle_cycles = 0;
        burst_left  = 0;
        start       = 1'b0;
        operands    = '0;
        rst_n       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_edge_operands();
        test_zero_operands();
        test_a_below_b();
        test_fibonacci_chains();
        test_random_pairs(252);
        drain_rows();

        $display("covered %0d operand pairs (%0d with b zero), %0d table rows checked",
                 pairs_sent, bad_pairs, rows_seen);
        if (error_count == 0 && pending_rows.size() == 0)
            $display("** extended_euclid_table_top: PASSED **");
        else
            $display("** extended_euclid_table_top: FAILED **");
        $finish;
    end
endmodule
